// File: design/tdpt_pkg.sv
package tdpt_pkg;

    localparam int NUMBER_BITS = 31;

    // A trial divisor never exceeds the integer square root plus two.
    localparam int DIV_BITS = (NUMBER_BITS + 1) / 2 + 2;
    localparam int SQ_BITS  = 2 * DIV_BITS;
    localparam int BIT_IDX_BITS = $clog2(NUMBER_BITS);

    localparam int STATE_BITS = 3;

    typedef logic [NUMBER_BITS-1:0] number_t;
    typedef logic [DIV_BITS-1:0]    divisor_t;
    typedef logic [SQ_BITS-1:0]     square_t;
    typedef logic [BIT_IDX_BITS-1:0] bit_idx_t;
    typedef logic [STATE_BITS-1:0]  state_t;

endpackage

// File: design/trial_division_prime_test.sv
// Trial-division primality test.
// A request on the s_ channel carries one unsigned candidate in s_candidate.
// The block answers each request with exactly one result on the m_ channel:
// m_not_prime is 1 for zero, one and composite values, and 0 for primes.
// Zero, one, two, three and even values are settled when the request is
// taken; they skip the division and pass through ST_DONE to the output
// register. Odd values are divided by 3, 5, 7 and so on up to the integer
// square root through one shared restoring remainder unit that handles one
// candidate bit per cycle; each trial divisor passes through ST_CHECK,
// ST_DIV once per candidate bit, and ST_STEP. The worst case, a 31-bit
// prime, takes about 23170 divisors. s_ready is high only while the
// sequencer is idle, so one request is in work at a time.
// The result is held in an output register; a new request is taken while it
// still waits, and a finished result waits in the sequencer until the
// receiver has taken the previous one. Reset is synchronous and active low;
// it empties the output register and returns the sequencer to idle.
module trial_division_prime_test (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tdpt_pkg::NUMBER_BITS-1:0] s_candidate,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_not_prime
);

    localparam tdpt_pkg::state_t ST_IDLE  = 3'd0;
    localparam tdpt_pkg::state_t ST_CHECK = 3'd1;
    localparam tdpt_pkg::state_t ST_DIV   = 3'd2;
    localparam tdpt_pkg::state_t ST_STEP  = 3'd3;
    localparam tdpt_pkg::state_t ST_DONE  = 3'd4;

    localparam tdpt_pkg::bit_idx_t TOP_BIT = tdpt_pkg::BIT_IDX_BITS'(tdpt_pkg::NUMBER_BITS - 1);

    tdpt_pkg::state_t   state_reg, state_next;
    tdpt_pkg::number_t  n_reg, n_next;
    tdpt_pkg::divisor_t d_reg, d_next;
    tdpt_pkg::divisor_t rem_reg, rem_next;
    tdpt_pkg::square_t  sq_reg, sq_next;
    tdpt_pkg::bit_idx_t bit_reg, bit_next;
    logic               res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_not_prime_reg, m_not_prime_next;

    logic [tdpt_pkg::DIV_BITS:0] r_shift;
    tdpt_pkg::divisor_t          r_diff;
    tdpt_pkg::divisor_t          r_new;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_not_prime = m_not_prime_reg;

    always_comb begin
        r_shift = {rem_reg, n_reg[bit_reg]};
        r_diff  = r_shift[tdpt_pkg::DIV_BITS-1:0] - d_reg;
        if (r_shift >= {1'b0, d_reg}) begin
            r_new = r_diff;
        end else begin
            r_new = r_shift[tdpt_pkg::DIV_BITS-1:0];
        end
    end

    always_comb begin
        state_next       = state_reg;
        n_next           = n_reg;
        d_next           = d_reg;
        rem_next         = rem_reg;
        sq_next          = sq_reg;
        bit_next         = bit_reg;
        res_next         = res_reg;
        m_valid_next     = m_valid_reg;
        m_not_prime_next = m_not_prime_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n_next = s_candidate;
                    d_next = tdpt_pkg::DIV_BITS'(3);
                    sq_next = tdpt_pkg::SQ_BITS'(9);
                    if (s_candidate < tdpt_pkg::NUMBER_BITS'(2)) begin
                        res_next   = 1'b1;
                        state_next = ST_DONE;
                    end else if (s_candidate < tdpt_pkg::NUMBER_BITS'(4)) begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end else if (!s_candidate[0]) begin
                        res_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (sq_reg > tdpt_pkg::SQ_BITS'(n_reg)) begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    rem_next   = '0;
                    bit_next   = TOP_BIT;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = r_new;
                if (bit_reg == '0) begin
                    state_next = ST_STEP;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_STEP: begin
                if (rem_reg == '0) begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    // (d + 2)^2 = d^2 + 4d + 4
                    sq_next = sq_reg + tdpt_pkg::SQ_BITS'({d_reg, 2'b00})
                              + tdpt_pkg::SQ_BITS'(4);
                    d_next     = d_reg + tdpt_pkg::DIV_BITS'(2);
                    state_next = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_not_prime_next = res_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg           <= n_next;
        d_reg           <= d_next;
        rem_reg         <= rem_next;
        sq_reg          <= sq_next;
        bit_reg         <= bit_next;
        res_reg         <= res_next;
        m_not_prime_reg <= m_not_prime_next;
    end

endmodule
